@@ rtl/aids_pkg.sv @@
// Shared types and constants for the packed array core.
// Holds sizes, operation and status codes, and the cell control bundle.
// No dependencies.
package aids_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_SORT   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  // What every cell does in this cycle
  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_DELETE,
    MODE_ROTATE,
    MODE_SORT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t                mode;
    logic [CNT_W-1:0]          pos;
    logic [CNT_W-1:0]          count;
    logic signed [DATA_W-1:0]  key;
    logic signed [DATA_W-1:0]  first;
    logic                      phase;
  } cell_ctrl_t;

endpackage

@@ rtl/aids_cell.sv @@
// One storage cell of the array chain: holds a single entry.
// Takes the value of a neighbor, a new key or a compare-exchange result.
// Depends on aids_pkg.
module aids_cell (
  input  logic                               clk,
  input  aids_pkg::cell_ctrl_t               ctrl,
  input  logic [aids_pkg::IDX_W-1:0]         idx,
  input  logic signed [aids_pkg::DATA_W-1:0] left_val,
  input  logic signed [aids_pkg::DATA_W-1:0] right_val,
  output logic signed [aids_pkg::DATA_W-1:0] val
);
  import aids_pkg::*;

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;
  logic [CNT_W-1:0]         idx_c;
  logic [CNT_W-1:0]         idx_p1;
  logic                     is_low;
  logic                     is_high;

  assign idx_c  = CNT_W'(idx);
  assign idx_p1 = idx_c + CNT_W'(1);

  // Pair membership for the odd-even exchange pass
  assign is_low  = (idx[0] == ctrl.phase) && (idx_p1 < ctrl.count);
  assign is_high = (idx[0] != ctrl.phase) && (idx_c != '0) && (idx_c < ctrl.count);

  // Select next value of this cell
  always_comb begin
    val_nxt = val_r;
    case (ctrl.mode)
      MODE_INSERT: begin
        if (idx_c == ctrl.pos) begin
          val_nxt = ctrl.key;
        end else if (idx_c > ctrl.pos && idx_c <= ctrl.count) begin
          val_nxt = left_val;
        end
      end
      MODE_DELETE: begin
        if (idx_c >= ctrl.pos && idx_p1 < ctrl.count) begin
          val_nxt = right_val;
        end
      end
      MODE_ROTATE: begin
        if (idx_p1 < ctrl.count) begin
          val_nxt = right_val;
        end else if (idx_p1 == ctrl.count) begin
          val_nxt = ctrl.first;
        end
      end
      MODE_SORT: begin
        if (is_low && (val_r > right_val)) begin
          val_nxt = right_val;
        end else if (is_high && (left_val > val_r)) begin
          val_nxt = left_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

@@ rtl/array_insert_delete_sort_search_core.sv @@
// Top level of the packed signed array core: control sequencer and cell chain.
// Depends on aids_pkg and aids_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries op, position and value; the
//   result channel (out_valid/out_ready) carries status, data, found_at,
//   entries and last. One transaction is worked on at a time.
//   Insert and delete shift all later cells at once, and the result is registered
//   on acceptance. Sort runs DEPTH odd-even exchange passes across the chain,
//   one per cycle, then registers its result.
//   Search rotates the chain once around comparing the head
//   cell with the key. Read rotates the chain too and emits the head cell
//   each step, one result per cycle while the receiver takes them, last set
//   on the final one.
//   Empty reads and searches, failed checks and a sort of fewer than two
//   entries answer straight from idle; unused op codes are consumed without a result.
//   The next transaction is accepted once the previous result has been taken
//   and the sequencer is idle.
//   Reset clears the entry count and the sequencer; the cells are not cleared
//   and entries above the count are never shown.
//   When the receiver stalls, the result register holds and read stops
//   rotating until the pending result is taken.
module array_insert_delete_sort_search_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [aids_pkg::OP_W-1:0]          in_op,
  input  logic [aids_pkg::CNT_W-1:0]         in_position,
  input  logic signed [aids_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [aids_pkg::ST_W-1:0]          out_status,
  output logic signed [aids_pkg::DATA_W-1:0] out_data,
  output logic [aids_pkg::CNT_W-1:0]         out_found_at,
  output logic [aids_pkg::CNT_W-1:0]         out_entries,
  output logic                               out_last
);
  import aids_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_SCAN,
    S_READ
  } state_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         found_at;
    logic [CNT_W-1:0]         entries;
    logic                     last;
  } res_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         step_r, step_nxt;
  logic [CNT_W-1:0]         found_r, found_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     out_valid_r, out_valid_nxt;
  res_t                     res_r, res_nxt;

  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] cell_val [DEPTH];
  logic                     out_free;
  logic                     accept;
  logic [CNT_W-1:0]         step_p1;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept   = in_valid && in_ready;
  assign step_p1  = step_r + CNT_W'(1);

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (i == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end
    aids_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .idx       (IDX_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[i])
    );
  end

  // Sequencer next state, cell control and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;

    ctrl.mode  = MODE_HOLD;
    ctrl.pos   = in_position;
    ctrl.count = count_r;
    ctrl.key   = in_value;
    ctrl.first = cell_val[0];
    ctrl.phase = step_r[0];

    // Drop a result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                res_nxt = '{ST_FULL, '0, '0, count_r, 1'b1};
              end else if (in_position > count_r) begin
                res_nxt = '{ST_BADPOS, '0, '0, count_r, 1'b1};
              end else begin
                ctrl.mode = MODE_INSERT;
                count_nxt = count_r + CNT_W'(1);
                res_nxt   = '{ST_OK, '0, '0, count_r + CNT_W'(1), 1'b1};
              end
            end
            OP_DELETE: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                res_nxt = '{ST_EMPTY, '0, '0, count_r, 1'b1};
              end else if (in_position >= count_r) begin
                res_nxt = '{ST_BADPOS, '0, '0, count_r, 1'b1};
              end else begin
                ctrl.mode = MODE_DELETE;
                count_nxt = count_r - CNT_W'(1);
                res_nxt   = '{ST_OK, cell_val[in_position[IDX_W-1:0]], '0,
                             count_r - CNT_W'(1), 1'b1};
              end
            end
            OP_SORT: begin
              if (count_r < CNT_W'(2)) begin
                out_valid_nxt = 1'b1;
                res_nxt       = '{ST_OK, '0, '0, count_r, 1'b1};
              end else begin
                state_nxt = S_SORT;
                step_nxt  = '0;
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                res_nxt       = '{ST_NOTFOUND, '0, '0, count_r, 1'b1};
              end else begin
                state_nxt = S_SCAN;
                step_nxt  = '0;
                found_nxt = '0;
                key_nxt   = in_value;
              end
            end
            OP_READ: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                res_nxt       = '{ST_EMPTY, '0, '0, count_r, 1'b1};
              end else begin
                state_nxt = S_READ;
                step_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end

      // Odd-even exchange passes over the whole chain
      S_SORT: begin
        ctrl.mode = MODE_SORT;
        step_nxt  = step_p1;
        if (step_r == CNT_W'(DEPTH - 1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_nxt       = '{ST_OK, '0, '0, count_r, 1'b1};
        end
      end

      // Rotate once around, compare the head with the key
      S_SCAN: begin
        ctrl.mode = MODE_ROTATE;
        step_nxt  = step_p1;
        if (found_r == '0 && cell_val[0] == key_r) begin
          found_nxt = step_p1;
        end
        if (step_p1 == count_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (found_nxt != '0) begin
            res_nxt = '{ST_OK, '0, found_nxt, count_r, 1'b1};
          end else begin
            res_nxt = '{ST_NOTFOUND, '0, '0, count_r, 1'b1};
          end
        end
      end

      // Emit the head cell and rotate, one step per free output slot
      S_READ: begin
        if (out_free) begin
          ctrl.mode     = MODE_ROTATE;
          step_nxt      = step_p1;
          out_valid_nxt = 1'b1;
          res_nxt       = '{ST_OK, cell_val[0], '0, count_r, step_p1 == count_r};
          if (step_p1 == count_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = res_r.status;
  assign out_data     = res_r.data;
  assign out_found_at = res_r.found_at;
  assign out_entries  = res_r.entries;
  assign out_last     = res_r.last;

  // The entry count never passes the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // A good insert grows the count by exactly one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_INSERT && count_r != CNT_W'(DEPTH) &&
     in_position <= count_r) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the count");

  // Multi-cycle operations never run on an empty array
  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ || state_r == S_SCAN) |-> (count_r != '0))
    else $error("scan or read on empty array");

  // Count is steady while the chain is being walked
  a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(count_r))
    else $error("count changed during a walk");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for array_insert_delete_sort_search_core: directed and random
// insert/delete/sort/search/read traffic against a behavioral array predictor.
// Depends on aids_pkg and the RTL of the core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aids_pkg::*;

  // Op codes the core consumes without a result
  localparam logic [OP_W-1:0]  OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0]  OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0]  OP_SPARE_HI  = 3'd7;
  localparam logic [CNT_W-1:0] POS_TOP      = '1;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         found_at;
    logic [CNT_W-1:0]         entries;
    logic                     last;
  } array_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          in_op;
  logic [CNT_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [ST_W-1:0]          out_status;
  logic signed [DATA_W-1:0] out_data;
  logic [CNT_W-1:0]         out_found_at;
  logic [CNT_W-1:0]         out_entries;
  logic                     out_last;

  // Predictor state: shadow of the packed array
  logic signed [DATA_W-1:0] arr_store [DEPTH];
  int                       arr_count = 0;
  array_result_t            pending_results [$];

  int fail_count   = 0;
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;
  bit hold_off_req = 1'b0;

  always #1ns clk = ~clk;

  array_insert_delete_sort_search_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_position  (in_position),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_found_at (out_found_at),
    .out_entries  (out_entries),
    .out_last     (out_last)
  );

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void push_result(logic [ST_W-1:0] status, logic signed [DATA_W-1:0] data,
                                      logic [CNT_W-1:0] found_at, logic last);
    array_result_t r;
    r.status   = status;
    r.data     = data;
    r.found_at = found_at;
    r.entries  = arr_count[CNT_W-1:0];
    r.last     = last;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted transaction to the shadow array and queue its results
  function automatic void predict_array_op(logic [OP_W-1:0] op, logic [CNT_W-1:0] pos,
                                           logic signed [DATA_W-1:0] val);
    logic signed [DATA_W-1:0] gone;
    logic signed [DATA_W-1:0] tmp;
    int hit;
    hit = 0;
    case (op)
      OP_INSERT: begin
        if (arr_count >= DEPTH) begin
          push_result(ST_FULL, '0, '0, 1'b1);
        end else if (int'(pos) > arr_count) begin
          push_result(ST_BADPOS, '0, '0, 1'b1);
        end else begin
          for (int k = arr_count; k > int'(pos); k--) arr_store[k] = arr_store[k-1];
          arr_store[pos] = val;
          arr_count++;
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (arr_count == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else if (int'(pos) >= arr_count) begin
          push_result(ST_BADPOS, '0, '0, 1'b1);
        end else begin
          gone = arr_store[pos];
          for (int k = int'(pos); k + 1 < arr_count; k++) arr_store[k] = arr_store[k+1];
          arr_count--;
          push_result(ST_OK, gone, '0, 1'b1);
        end
      end
      OP_SORT: begin
        // exchange sort: each slot against every later one
        for (int i = 0; i < arr_count; i++) begin
          for (int j = i + 1; j < arr_count; j++) begin
            if (arr_store[i] > arr_store[j]) begin
              tmp          = arr_store[i];
              arr_store[i] = arr_store[j];
              arr_store[j] = tmp;
            end
          end
        end
        push_result(ST_OK, '0, '0, 1'b1);
      end
      OP_SEARCH: begin
        for (int k = 0; k < arr_count && hit == 0; k++) begin
          if (arr_store[k] == val) hit = k + 1;
        end
        if (hit != 0) push_result(ST_OK, '0, hit[CNT_W-1:0], 1'b1);
        else push_result(ST_NOTFOUND, '0, '0, 1'b1);
      end
      OP_READ: begin
        if (arr_count == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int k = 0; k < arr_count; k++) begin
            push_result(ST_OK, arr_store[k], '0, k == arr_count - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom;
    if (r < 80) return int'($urandom_range(0, 15)) - 8;
    case ($urandom_range(0, 3))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Key that mostly hits an existing entry when there is one
  function automatic logic signed [DATA_W-1:0] pick_key();
    if (arr_count > 0 && $urandom_range(0, 99) < 70) return arr_store[$urandom_range(0, arr_count-1)];
    return pick_value();
  endfunction

  // Offer one transaction and predict it at the accepting edge; valid stays up on return
  task automatic send_item(logic [OP_W-1:0] op, logic [CNT_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 99) < 25) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
    predict_array_op(op, pos, val);
  endtask

  // Drop valid and hold until every queued result has been taken
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_array();
    send_item(OP_READ, '0, '0);
    send_item(OP_DELETE, '0, '0);
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_SORT, '0, '0);
    send_item(OP_INSERT, 5'd1, 32'sd9);
    send_item(OP_INSERT, '0, 32'sd7);
    send_item(OP_SORT, '0, '0);
    send_item(OP_SEARCH, '0, 32'sd7);
    send_item(OP_DELETE, '0, '0);
  endtask

  task automatic test_basic_edits();
    send_item(OP_INSERT, '0, VAL_MIN);
    send_item(OP_INSERT, 5'd1, VAL_MAX);
    send_item(OP_INSERT, 5'd1, '0);
    send_item(OP_INSERT, '0, '1);
    send_item(OP_SEARCH, '0, VAL_MAX);
    send_item(OP_SEARCH, POS_TOP, 32'sd12345);
    send_item(OP_DELETE, 5'd4, '0);
    send_item(OP_DELETE, POS_TOP, '0);
    send_item(OP_DELETE, 5'd1, '0);
    send_item(OP_SORT, '0, '0);
    send_item(OP_READ, '0, '0);
    send_item(OP_SPARE_LO, 5'd3, VAL_MAX);
    send_item(OP_SPARE_MID, POS_TOP, VAL_MIN);
    send_item(OP_SPARE_HI, '0, '1);
  endtask

  // Fill to capacity, stall the receiver across a full read, then drain to empty
  task automatic test_fill_and_drain();
    while (arr_count < DEPTH)
      send_item(OP_INSERT, CNT_W'($urandom_range(0, arr_count)), pick_value());
    send_item(OP_INSERT, POS_TOP, pick_value());
    send_item(OP_INSERT, CNT_W'($urandom_range(0, DEPTH)), pick_value());
    // keep offering while the receiver holds off
    tx_idle_en   = 1'b0;
    hold_off_req = 1'b1;
    send_item(OP_READ, '0, '0);
    send_item(OP_SORT, '0, '0);
    send_item(OP_READ, '0, '0);
    send_item(OP_SEARCH, '0, pick_key());
    send_item(OP_SEARCH, '0, pick_key());
    tx_idle_en = 1'b1;
    while (arr_count > 0)
      send_item(OP_DELETE, CNT_W'($urandom_range(0, arr_count-1)), pick_value());
    send_item(OP_DELETE, CNT_W'($urandom_range(0, 31)), '0);
    send_item(OP_READ, '0, '0);
  endtask

  task automatic test_random_mix(int n_items);
    int r;
    int ins_w;
    for (int n = 0; n < n_items; n++) begin
      // switch idling on and off in stretches
      if (n % 20 == 0) begin
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_idle_en = $urandom_range(0, 3) != 0;
      end
      // pause the sender until everything has come back
      if (n == n_items / 2) wait_results_drained();
      ins_w = (arr_count < DEPTH / 2) ? 45 : 30;
      r = $urandom_range(0, 99);
      if (r < ins_w) begin
        if ($urandom_range(0, 9) != 0)
          send_item(OP_INSERT, CNT_W'($urandom_range(0, arr_count)), pick_value());
        else send_item(OP_INSERT, CNT_W'($urandom_range(0, 31)), pick_value());
      end else if (r < ins_w + 28) begin
        if (arr_count > 0 && $urandom_range(0, 9) != 0)
          send_item(OP_DELETE, CNT_W'($urandom_range(0, arr_count-1)), pick_value());
        else send_item(OP_DELETE, CNT_W'($urandom_range(0, 31)), pick_value());
      end else if (r < ins_w + 42) begin
        send_item(OP_SEARCH, CNT_W'($urandom_range(0, 31)), pick_key());
      end else if (r < ins_w + 48) begin
        send_item(OP_SORT, CNT_W'($urandom_range(0, 31)), pick_value());
      end else if (r < ins_w + 55) begin
        send_item(OP_READ, CNT_W'($urandom_range(0, 31)), pick_value());
      end else begin
        send_item(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                  CNT_W'($urandom_range(0, 31)), $urandom);
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver: random stalls plus one counted hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        stall_left = HOLD_OFF_CYCLES - 1;
      end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each taken result against the oldest expectation
  always @(posedge clk) begin
    array_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_fail($sformatf("unexpected result: st=%0d data=%0d at=%0d n=%0d last=%0b",
                            out_status, out_data, out_found_at, out_entries, out_last));
      end else begin
        want = pending_results.pop_front();
        if (want.status !== out_status || want.data !== out_data ||
            want.found_at !== out_found_at || want.entries !== out_entries ||
            want.last !== out_last) begin
          note_fail($sformatf({"mismatch: exp st=%0d data=%0d at=%0d n=%0d last=%0b, ",
                               "got st=%0d data=%0d at=%0d n=%0d last=%0b"},
                              want.status, want.data, want.found_at, want.entries, want.last,
                              out_status, out_data, out_found_at, out_entries, out_last));
        end
      end
    end
  end

  initial begin
    in_valid    <= 1'b0;
    in_op       <= OP_INSERT;
    in_position <= '0;
    in_value    <= '0;
    rst_n       <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_array();
    test_basic_edits();
    test_fill_and_drain();
    test_random_mix(170);
    wait_results_drained();
    repeat (4 * DEPTH) @(posedge clk);
    if (fail_count == 0) begin
      $display("** array_insert_delete_sort_search_core: PASSED **");
    end else begin
      $display("** array_insert_delete_sort_search_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3ms;
    $display("** array_insert_delete_sort_search_core: FAILED **");
    $finish;
  end

endmodule
